// ===== sv/albp_pkg.sv =====
`default_nettype none
package albp_pkg;

  // Register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_W_W    = 11;
  localparam int CFG_H_W    = 12;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int WIDTH_RESET   = 640;
  localparam int HEIGHT_RESET  = 480;
  localparam int SIZE_MIN      = 3;

  localparam int PIX_W  = 8;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 10;
  localparam int CODE_W = 8;

  // Queue depths
  localparam int JOB_DEPTH = 4;
  localparam int RES_DEPTH = 16;

  // floor(x/9) by reciprocal: exact for x < 2^12 and for x < 2^20
  localparam int RECIP9_AVE = 3641;
  localparam int AVE_SHIFT  = 15;
  localparam int RECIP9_Q   = 233017;
  localparam int Q_SHIFT    = 21;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } meta_t;

  // Window in neighbour order: 0..7 clockwise from top-left, 8 = center
  typedef struct packed {
    logic [8:0][PIX_W-1:0] pix;
    meta_t                 meta;
  } job_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    meta_t             meta;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/albp_ram.sv =====
`default_nettype none
module albp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/albp_fifo.sv =====
`default_nettype none
module albp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           push_data,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           head,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  // caller never pushes into a full queue
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH-1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH-1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  assign head  = mem_r[rptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule
`default_nettype wire

// ===== sv/albp_front.sv =====
`default_nettype none
module albp_front import albp_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_push,
  input  wire logic [PIX_W-1:0]                 in_pixel,
  output logic                                  in_full,
  input  wire logic                             cfg_we,
  input  wire logic [CFG_IDX_W-1:0]             cfg_index,
  input  wire logic [CFG_DATA_W-1:0]            cfg_data,
  input  wire logic [$clog2(JOB_DEPTH+1)-1:0]   job_count,
  output logic                                  job_push,
  output job_t                                  job
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CW1 = $clog2(MAX_WIDTH+1);
  localparam int EW  = (CW1 > CFG_W_W) ? CW1 : CFG_W_W;
  localparam int JCW = $clog2(JOB_DEPTH+1);

  logic [CFG_W_W-1:0] cfg_w_r, cfg_w_nxt;
  logic [CFG_H_W-1:0] cfg_h_r, cfg_h_nxt;
  logic [EW-1:0]      eff_w;
  logic [ROW_W-1:0]   eff_h;

  logic [CW-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               col_end, row_end, accept;

  // stage 0: line-store read in flight
  logic               s0_v_r;
  logic [PIX_W-1:0]   s0_px_r;
  logic [CW-1:0]      s0_col_r;
  logic [ROW_W-1:0]   s0_row_r;
  logic               s0_int_r, s0_last_r;

  logic [PIX_W-1:0]   top_rd, mid_rd;
  logic [2:0][2:0][PIX_W-1:0] win_r, win_nxt;

  always_comb begin
    if (EW'(cfg_w_r) < EW'(SIZE_MIN)) begin
      eff_w = EW'(SIZE_MIN);
    end else if (EW'(cfg_w_r) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(cfg_w_r);
    end
    eff_h = (cfg_h_r < ROW_W'(SIZE_MIN)) ? ROW_W'(SIZE_MIN) : cfg_h_r;
  end

  assign in_full = ({1'b0, job_count} + (JCW+1)'(s0_v_r)) >= (JCW+1)'(JOB_DEPTH);
  assign accept  = in_push && !in_full;
  assign col_end = (EW'(col_r) == eff_w - 1'b1);
  assign row_end = (row_r == eff_h - 1'b1);

  always_comb begin
    cfg_w_nxt = cfg_w_r;
    cfg_h_nxt = cfg_h_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    if (accept) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    // a size write restarts the frame
    if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          cfg_w_nxt = cfg_data[CFG_W_W-1:0];
          col_nxt   = '0;
          row_nxt   = '0;
        end
        REG_IMAGE_HEIGHT: begin
          cfg_h_nxt = cfg_data[CFG_H_W-1:0];
          col_nxt   = '0;
          row_nxt   = '0;
        end
        default: begin
          cfg_w_nxt = cfg_w_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= CFG_W_W'(WIDTH_RESET);
      cfg_h_r <= CFG_H_W'(HEIGHT_RESET);
      col_r   <= '0;
      row_r   <= '0;
      s0_v_r  <= 1'b0;
    end else begin
      cfg_w_r <= cfg_w_nxt;
      cfg_h_r <= cfg_h_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      s0_v_r  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_px_r   <= in_pixel;
      s0_col_r  <= col_r;
      s0_row_r  <= row_r;
      s0_int_r  <= (row_r >= ROW_W'(2)) && (col_r >= CW'(2));
      s0_last_r <= row_end && col_end;
    end
  end

  // top row store: read at accept, rewritten with the middle row in the next cycle
  albp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_top_ram (
    .clk   (clk),
    .we    (s0_v_r),
    .waddr (s0_col_r),
    .wdata (mid_rd),
    .re    (accept),
    .raddr (col_r),
    .rdata (top_rd)
  );

  albp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_ram (
    .clk   (clk),
    .we    (s0_v_r),
    .waddr (s0_col_r),
    .wdata (s0_px_r),
    .re    (accept),
    .raddr (col_r),
    .rdata (mid_rd)
  );

  always_comb begin
    win_nxt = win_r;
    if (s0_v_r) begin
      for (int i = 0; i < 3; i++) begin
        win_nxt[i][0] = win_r[i][1];
        win_nxt[i][1] = win_r[i][2];
      end
      win_nxt[0][2] = top_rd;
      win_nxt[1][2] = mid_rd;
      win_nxt[2][2] = s0_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else begin
      win_r <= win_nxt;
    end
  end

  always_comb begin
    job.pix[0]    = win_nxt[0][0];
    job.pix[1]    = win_nxt[0][1];
    job.pix[2]    = win_nxt[0][2];
    job.pix[3]    = win_nxt[1][2];
    job.pix[4]    = win_nxt[2][2];
    job.pix[5]    = win_nxt[2][1];
    job.pix[6]    = win_nxt[2][0];
    job.pix[7]    = win_nxt[1][0];
    job.pix[8]    = win_nxt[1][1];
    job.meta.row  = s0_row_r - 1'b1;
    job.meta.col  = COL_W'(int'(s0_col_r) - 1);
    job.meta.last = s0_last_r;
  end

  assign job_push = s0_v_r && s0_int_r;

endmodule
`default_nettype wire

// ===== sv/albp_back.sv =====
`default_nettype none
module albp_back import albp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic job_empty,
  input  wire job_t job,
  output logic      job_pop,
  input  wire logic res_pop,
  output logic      res_push,
  output res_t      res
);

  localparam int CRW = $clog2(RES_DEPTH+1);

  logic [CRW-1:0] credit_r, credit_nxt;
  logic           b1_v_r, b2_v_r, b3_v_r, b4_v_r, b5_v_r, b6_v_r;

  logic [8:0][PIX_W-1:0] b1_pix_r, b2_pix_r;
  logic [11:0]           sum9;
  logic [11:0]           b1_sum_r;
  logic [23:0]           ave_prod;
  logic [PIX_W-1:0]      b2_ave_r;
  logic signed [8:0]     dev [9];
  logic signed [17:0]    dsq [9];
  logic [8:0][15:0]      b3_sq_r;
  logic [19:0]           sq_tot;
  logic [19:0]           b4_tot_r;
  logic [7:0][15:0]      b4_sq_r, b5_sq_r;
  logic [37:0]           q_prod;
  logic [15:0]           b5_q_r;
  logic [CODE_W-1:0]     code;
  meta_t                 b1_meta_r, b2_meta_r, b3_meta_r, b4_meta_r, b5_meta_r;
  res_t                  b6_res_r;

  // credits cover every item in the pipe or waiting in the result queue
  assign job_pop = !job_empty && (credit_r < CRW'(RES_DEPTH));

  always_comb begin
    credit_nxt = credit_r;
    if (job_pop && !res_pop) begin
      credit_nxt = credit_r + 1'b1;
    end else if (res_pop && !job_pop) begin
      credit_nxt = credit_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
      b1_v_r   <= 1'b0;
      b2_v_r   <= 1'b0;
      b3_v_r   <= 1'b0;
      b4_v_r   <= 1'b0;
      b5_v_r   <= 1'b0;
      b6_v_r   <= 1'b0;
    end else begin
      credit_r <= credit_nxt;
      b1_v_r   <= job_pop;
      b2_v_r   <= b1_v_r;
      b3_v_r   <= b2_v_r;
      b4_v_r   <= b3_v_r;
      b5_v_r   <= b4_v_r;
      b6_v_r   <= b5_v_r;
    end
  end

  always_comb begin
    sum9 = '0;
    for (int k = 0; k < 9; k++) begin
      sum9 = sum9 + 12'(job.pix[k]);
    end
  end

  assign ave_prod = {12'd0, b1_sum_r} * 24'(RECIP9_AVE);

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      dev[k] = $signed({1'b0, b2_pix_r[k]}) - $signed({1'b0, b2_ave_r});
      dsq[k] = dev[k] * dev[k];
    end
  end

  always_comb begin
    sq_tot = '0;
    for (int k = 0; k < 9; k++) begin
      sq_tot = sq_tot + 20'(b3_sq_r[k]);
    end
  end

  assign q_prod = {18'd0, b4_tot_r} * 38'(RECIP9_Q);

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      code[7-k] = (b5_sq_r[k] > b5_q_r);
    end
  end

  always_ff @(posedge clk) begin
    // B1: window sum
    b1_pix_r  <= job.pix;
    b1_sum_r  <= sum9;
    b1_meta_r <= job.meta;
    // B2: mean
    b2_pix_r  <= b1_pix_r;
    b2_ave_r  <= ave_prod[AVE_SHIFT +: PIX_W];
    b2_meta_r <= b1_meta_r;
    // B3: squared deviations
    for (int k = 0; k < 9; k++) begin
      b3_sq_r[k] <= dsq[k][15:0];
    end
    b3_meta_r <= b2_meta_r;
    // B4: total
    b4_tot_r  <= sq_tot;
    b4_sq_r   <= b3_sq_r[7:0];
    b4_meta_r <= b3_meta_r;
    // B5: variance
    b5_q_r    <= q_prod[Q_SHIFT +: 16];
    b5_sq_r   <= b4_sq_r;
    b5_meta_r <= b4_meta_r;
    // B6: pattern
    b6_res_r.code <= code;
    b6_res_r.meta <= b5_meta_r;
  end

  assign res_push = b6_v_r;
  assign res      = b6_res_r;

endmodule
`default_nettype wire

// ===== sv/adaptive_lbp_3x3_stddev_top.sv =====
// Adaptive 3x3 local binary pattern, threshold from the local std deviation.
//
// Input queue: drive in_pixel with in_push; a pixel is taken on a clock edge
// with in_push high and in_full low. Pixels arrive in raster order.
// Result queue: while out_empty is low, out_code/out_row/out_col/out_last show
// the oldest code; out_pop high takes it. One code per interior pixel, issued
// when pixel (row+1, col+1) arrives; border codes are zero and left to the user.
// Config: cfg_we writes cfg_data into register cfg_index (0 width, 1 height);
// either write restarts the frame. Write only while the block is drained.
// Throughput: one pixel per clock while in_full is low. A code reaches the
// result ports after the pixel that completes its window is taken, through
// the line-store read stage, the job queue, the six-stage mean/variance
// pipeline and the result queue.
// Stall: the back end holds a credit for every item it launches, so a code
// always has room in the 16-item result queue; when the consumer stops popping
// the 4-item job queue fills and in_full rises. in_full depends on registers
// only. Reset (synchronous, rst_n low) empties both queues and clears counters,
// window and sizes to 640x480. Line stores hold garbage until the first two
// rows are written, which never reach a code.
`default_nettype none
module adaptive_lbp_3x3_stddev_top import albp_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  input  wire logic [PIX_W-1:0]      in_pixel,
  output logic                       in_full,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output logic      [CODE_W-1:0]     out_code,
  output logic      [ROW_W-1:0]      out_row,
  output logic      [COL_W-1:0]      out_col,
  output logic                       out_last,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic                           job_push, job_pop, job_empty;
  job_t                           job_in, job_head;
  logic [$clog2(JOB_DEPTH+1)-1:0] job_count;
  logic                           res_push, res_pop;
  res_t                           res_in, res_head;

  // front: counters, line stores, window, interior test
  albp_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_pixel  (in_pixel),
    .in_full   (in_full),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_count (job_count),
    .job_push  (job_push),
    .job       (job_in)
  );

  // decouples front and back
  albp_fifo #(.WIDTH($bits(job_t)), .DEPTH(JOB_DEPTH)) u_job_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .head      (job_head),
    .empty     (job_empty),
    .count     (job_count)
  );

  // back: mean, variance, pattern
  albp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job       (job_head),
    .job_pop   (job_pop),
    .res_pop   (res_pop),
    .res_push  (res_push),
    .res       (res_in)
  );

  assign res_pop = out_pop && !out_empty;

  albp_fifo #(.WIDTH($bits(res_t)), .DEPTH(RES_DEPTH)) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .pop       (res_pop),
    .head      (res_head),
    .empty     (out_empty),
    .count     ()
  );

  assign out_code = res_head.code;
  assign out_row  = res_head.meta.row;
  assign out_col  = res_head.meta.col;
  assign out_last = res_head.meta.last;

endmodule
`default_nettype wire

// ===== sv/albp_checker.sv =====
`default_nettype none
module albp_checker import albp_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_full,
  input wire logic                  out_empty,
  input wire logic                  out_pop,
  input wire logic [CODE_W-1:0]     out_code,
  input wire logic [ROW_W-1:0]      out_row,
  input wire logic [COL_W-1:0]      out_col,
  input wire logic                  out_last
);

  // next code starts a frame: after reset or after the frame's last code
  logic frame_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_start_r <= 1'b1;
    end else if (out_pop && !out_empty) begin
      frame_start_r <= out_last;
    end
  end

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && frame_start_r |-> out_row == ROW_W'(1) && out_col == COL_W'(1))
    else $error("frame does not start at first interior pixel");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_code) && $stable(out_row)
      && $stable(out_col) && $stable(out_last))
    else $error("waiting item changed");

endmodule

bind adaptive_lbp_3x3_stddev_top albp_checker u_albp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_code  (out_code),
  .out_row   (out_row),
  .out_col   (out_col),
  .out_last  (out_last)
);
`default_nettype wire

// ===== dv/adaptive_lbp_3x3_stddev_top_tb.sv =====
`timescale 1ns / 1ps

module adaptive_lbp_3x3_stddev_top_tb;
  import albp_pkg::*;

  // No-accept cycles before the run is declared hung.
  // The longest legal quiet stretch is the consumer backlog hold, BACKLOG_HOLD long.
  localparam int unsigned QUIET_LIMIT   = 5000;
  // Cycles to let the pipe empty after the last code.
  // The pipe runs through the line-store read stage and the back-end pipeline, plus a 4-deep job queue.
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned RANDOM_ITEMS  = 650;
  localparam int unsigned BACKLOG_AT    = 40;   // hold pop once this many codes are in
  localparam int unsigned BACKLOG_HOLD  = 400;
  localparam int unsigned HEIGHT_CAP    = (1 << CFG_H_W) - 1;

  // Directed 5x4 frame, raster order.
  // Centers (1,1): 0/255 checkerboard beside a 128 column. (1,3): flat 128 with one bright spike.
  // Row 3 uses 170/85 so every pixel bit toggles.
  localparam logic [20*PIX_W-1:0] CORNER_PIXELS = {
    8'd0,   8'd255, 8'd128, 8'd128, 8'd128,
    8'd255, 8'd0,   8'd128, 8'd128, 8'd128,
    8'd0,   8'd255, 8'd128, 8'd128, 8'd255,
    8'd170, 8'd85,  8'd128, 8'd128, 8'd0
  };

  typedef enum int {PIX_UNIFORM, PIX_GENTLE, PIX_FLAT, PIX_EXTREME} pix_mode_t;

  // Tracks the pattern codes the block owes and checks them in arrival order.
  class lbp_code_check;
    int unsigned       width_reg;
    int unsigned       height_reg;
    logic [PIX_W-1:0]  upper_line [MAX_WIDTH_DEF];  // two rows back
    logic [PIX_W-1:0]  lower_line [MAX_WIDTH_DEF];  // one row back
    logic [PIX_W-1:0]  win [3][3];                  // [row][col], col 2 newest
    int unsigned       col_pos;
    int unsigned       row_pos;
    res_t              codes_due [$];
    int unsigned       mismatches;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col_pos    = 0;
      row_pos    = 0;
      mismatches = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg < SIZE_MIN) return SIZE_MIN;
      if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < SIZE_MIN) return SIZE_MIN;
      if (height_reg > HEIGHT_CAP) return HEIGHT_CAP;
      return height_reg;
    endfunction

    function int unsigned pending();
      return codes_due.size();
    endfunction

    // Any register write restarts the frame; line stores and window persist.
    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
      if (idx == REG_IMAGE_WIDTH) width_reg = value[CFG_W_W-1:0];
      else height_reg = value[CFG_H_W-1:0];
      col_pos = 0;
      row_pos = 0;
    endfunction

    function void add_pixel(input logic [PIX_W-1:0] pix);
      int unsigned      w, h, c, r, k, sum, ave, spread, q;
      int unsigned      nb [9];
      int               diff [9];
      logic [PIX_W-1:0] above, middle;
      logic [CODE_W-1:0] pattern;
      res_t             want;
      w = eff_width();
      h = eff_height();
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;
      above = upper_line[c];
      middle = lower_line[c];
      upper_line[c] = middle;
      lower_line[c] = pix;
      for (k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = above;
      win[1][2] = middle;
      win[2][2] = pix;

      if (r >= 2 && c >= 2) begin
        // neighbours clockwise from top-left, center last
        nb[0] = win[0][0]; nb[1] = win[0][1]; nb[2] = win[0][2];
        nb[3] = win[1][2]; nb[4] = win[2][2]; nb[5] = win[2][1];
        nb[6] = win[2][0]; nb[7] = win[1][0]; nb[8] = win[1][1];
        sum = 0;
        for (k = 0; k < 9; k++) sum += nb[k];
        ave = sum / 9;
        spread = 0;
        for (k = 0; k < 9; k++) begin
          diff[k] = int'(nb[k]) - int'(ave);
          spread += diff[k] * diff[k];
        end
        q = spread / 9;
        pattern = '0;
        for (k = 0; k < 8; k++)
          if (int'(diff[k] * diff[k]) > int'(q)) pattern[7 - k] = 1'b1;
        want.code      = pattern;
        want.meta.row  = ROW_W'(r - 1);
        want.meta.col  = COL_W'(c - 1);
        want.meta.last = (r == h - 1) && (c == w - 1);
        codes_due.push_back(want);
      end

      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    function void check_code(input res_t got);
      res_t want;
      if (codes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected code %02h row %0d col %0d last %0b",
                   got.code, got.meta.row, got.meta.col, got.meta.last);
        return;
      end
      want = codes_due.pop_front();
      if (got.code !== want.code || got.meta.row !== want.meta.row ||
          got.meta.col !== want.meta.col || got.meta.last !== want.meta.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected code %02h row %0d col %0d last %0b, got %02h %0d %0d %0b",
                   want.code, want.meta.row, want.meta.col, want.meta.last,
                   got.code, got.meta.row, got.meta.col, got.meta.last);
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_push   = 1'b0;
  logic [PIX_W-1:0]      in_pixel  = '0;
  logic                  in_full;
  logic                  out_empty;
  logic                  out_pop   = 1'b0;
  logic [CODE_W-1:0]     out_code;
  logic [ROW_W-1:0]      out_row;
  logic [COL_W-1:0]      out_col;
  logic                  out_last;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  lbp_code_check sb;
  res_t          popped;
  int unsigned   codes_taken  = 0;
  int unsigned   pop_hold     = 0;
  bit            backlog_done = 1'b0;
  bit            rx_steady    = 1'b0;   // consumer pops every cycle while set and no pop hold runs
  bit            tx_steady    = 1'b0;   // producer sends back to back while set
  int unsigned   quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  adaptive_lbp_3x3_stddev_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_pixel  (in_pixel),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_code  (out_code),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_last  (out_last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Offer one pixel, after a random idle gap, and hold it until taken.
  // Gaps: mostly none or short, a few long; none at all while tx_steady is set.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int unsigned gap, roll;
    roll = $urandom_range(0, 99);
    if (tx_steady || roll < 60) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else if (roll < 98) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if ($urandom_range(0, 99) == 0) tx_steady = !tx_steady;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push  <= 1'b1;
    in_pixel <= pix;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.add_pixel(pix);
  endtask

  // Back-to-back writes keep cfg_we high, so it is never dropped and raised in one step.
  task automatic apply_config(input bit set_w, input logic [CFG_DATA_W-1:0] wv,
                              input bit set_h, input logic [CFG_DATA_W-1:0] hv);
    if (set_w) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_IMAGE_WIDTH;
      cfg_data  <= wv;
      @(posedge clk);
      sb.write_reg(REG_IMAGE_WIDTH, wv);
    end
    if (set_h) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_IMAGE_HEIGHT;
      cfg_data  <= hv;
      @(posedge clk);
      sb.write_reg(REG_IMAGE_HEIGHT, hv);
    end
    cfg_we <= 1'b0;
  endtask

  // Stop sending, collect every owed code, then let border-only pixels finish.
  task automatic settle();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] make_pixel(input pix_mode_t mode, input int base);
    int v;
    case (mode)
      PIX_UNIFORM: v = $urandom_range(0, 255);
      PIX_GENTLE:  v = base + int'($urandom_range(0, 12)) - 6;   // hovers near the threshold
      PIX_FLAT:    v = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 255)) : base;
      default:     v = $urandom_range(0, 1) ? 255 : 0;
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[PIX_W-1:0];
  endfunction

  // Consumer: random pop gaps, steady stretches, and one long backlog hold.
  // The hold starts while the wide frame streams, so the queues fill and in_full rises.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        popped.code      = out_code;
        popped.meta.row  = out_row;
        popped.meta.col  = out_col;
        popped.meta.last = out_last;
        sb.check_code(popped);
        codes_taken++;
      end
      if (pop_hold > 0) begin
        pop_hold--;
        out_pop <= 1'b0;
      end else if (codes_taken >= BACKLOG_AT && !backlog_done) begin
        backlog_done = 1'b1;
        pop_hold = BACKLOG_HOLD;
        out_pop <= 1'b0;
      end else if (rx_steady || $urandom_range(0, 9) < 7) begin
        out_pop <= 1'b1;
      end else begin
        out_pop <= 1'b0;
        pop_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
      end
      if ($urandom_range(0, 149) == 0) rx_steady = !rx_steady;
    end
  end

  // Watchdog: counts cycles in which neither side moves an item.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned n, w, h, sel, random_items, i;
    int          base;
    bit          set_w, set_h;
    logic [CFG_DATA_W-1:0] wv, hv;
    pix_mode_t   mode;

    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset geometry is 640x480: a short run inside row 0 owes no code.
    repeat (20) send_pixel(PIX_W'($urandom_range(0, 255)));
    settle();

    // Directed 5x4 frame: extremes, checkerboard, spike, frame-end flag.
    apply_config(1'b1, CFG_DATA_W'(5), 1'b1, CFG_DATA_W'(4));
    for (i = 0; i < 20; i++) send_pixel(CORNER_PIXELS[(19 - i) * PIX_W +: PIX_W]);
    settle();

    // Sizes below the minimum clamp to 3x3; two frames wrap, then a partial third.
    apply_config(1'b1, CFG_DATA_W'(0), 1'b1, CFG_DATA_W'(1));
    repeat (22) send_pixel(PIX_W'($urandom_range(0, 255)));
    settle();

    // Wide frame of 200 pixels per row; height 2 clamps to 3.
    // One full frame reaches the last column and the frame-end flag.
    apply_config(1'b1, CFG_DATA_W'(200), 1'b1, CFG_DATA_W'(2));
    repeat (200 * 3) send_pixel(PIX_W'($urandom_range(0, 255)));
    settle();

    // Tallest frame, narrow, only its first rows.
    apply_config(1'b1, CFG_DATA_W'(3), 1'b1, '1);
    base = $urandom_range(0, 255);
    repeat (3 * 30) send_pixel(make_pixel(PIX_GENTLE, base));
    settle();

    // Random phases: mostly small frames, whole or cut short by the next write.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel < 15) wv = CFG_DATA_W'($urandom_range(3, 12));
      else if (sel < 18) wv = CFG_DATA_W'($urandom_range(0, 2));
      else wv = CFG_DATA_W'($urandom_range(13, 40));
      sel = $urandom_range(0, 19);
      if (sel < 16) hv = CFG_DATA_W'($urandom_range(3, 6));
      else if (sel < 19) hv = CFG_DATA_W'($urandom_range(0, 2));
      else hv = CFG_DATA_W'($urandom_range(4000, HEIGHT_CAP));
      set_w = ($urandom_range(0, 3) != 0);
      set_h = !set_w || $urandom_range(0, 1);
      if (sb.eff_width() > 64) set_w = 1'b1;   // leave the wide geometry behind
      apply_config(set_w, wv, set_h, hv);

      w = sb.eff_width();
      h = sb.eff_height();
      if (h > 64) n = w * $urandom_range(3, 10);
      else n = w * h * $urandom_range(1, 3) + ($urandom_range(0, 1) ? $urandom_range(1, w * h - 1) : 0);

      sel = $urandom_range(0, 99);
      if (sel < 40) mode = PIX_UNIFORM;
      else if (sel < 70) mode = PIX_GENTLE;
      else if (sel < 85) mode = PIX_FLAT;
      else mode = PIX_EXTREME;
      base = $urandom_range(0, 255);

      repeat (n) send_pixel(make_pixel(mode, base));
      random_items += n;
      settle();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
